// ===== hdl/lkv_pkg.sv =====
package lkv_pkg;

    // Field widths
    localparam int REQ_W     = 3;
    localparam int KEY_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 11;

    // Default table size
    localparam int LKV_CAPACITY = 1024;

    // Fan-in of one node of the match reduction tree
    localparam int TREE_RADIX = 16;

    // Request kinds; codes five to seven act as a lookup
    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 3'd0,
        REQ_TOUCH  = 3'd1,
        REQ_ASSIGN = 3'd2,
        REQ_DELETE = 3'd3,
        REQ_CLEAR  = 3'd4
    } lkv_req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } lkv_status_t;

    // Commands broadcast to every cell of the row
    typedef struct packed {
        logic compare;    // register the key match of this cell
        logic write_hit;  // matching cell takes the write value
        logic insert;     // cell at the fill position takes key and value
        logic shift;      // cells at or past the hit slot take their neighbor
    } lkv_cell_ctrl_t;

    // Registered tree levels needed to reduce n leaves
    function automatic int lkv_tree_levels(input int n);
        int lv;
        int span;
        lv   = 1;
        span = TREE_RADIX;
        while (span < n) begin
            span = span * TREE_RADIX;
            lv   = lv + 1;
        end
        return lv;
    endfunction

    // Start of tree level lvl (1 is next to the leaves) in the flat node array
    function automatic int lkv_level_base(input int lvl, input int levels);
        int base;
        base = 0;
        for (int j = 1; j < lvl; j++) begin
            base = base + TREE_RADIX ** (levels - j);
        end
        return base;
    endfunction

endpackage

// ===== hdl/lkv_cell.sv =====
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 10,
    parameter int CNT_W    = 11
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lkv_cell_ctrl_t            ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic [IDX_W-1:0]          slot,
    input  logic [KEY_W-1:0]          req_key,
    input  logic [VALUE_W-1:0]        wr_value,
    input  logic [KEY_W-1:0]          nb_key,
    input  logic [VALUE_W-1:0]        nb_value,
    output logic [KEY_W-1:0]          cell_key,
    output logic [VALUE_W-1:0]        cell_value,
    output logic [IDX_W+VALUE_W:0]    leaf
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);

    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               match_reg;
    logic               occupied;
    logic               match_next;

    // Entry is live only below the fill count
    assign occupied   = MY_POS < count;
    assign match_next = occupied && (key_reg == req_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            match_reg <= match_next;
        end
    end

    // Entry storage: update on hit, fill at the end, or close a gap on delete
    always_ff @(posedge clk)
    begin
        if (ctrl.write_hit && match_reg)
        begin
            value_reg <= wr_value;
        end
        else if (ctrl.insert && (MY_POS == count))
        begin
            key_reg   <= req_key;
            value_reg <= wr_value;
        end
        else if (ctrl.shift && (MY_IDX >= slot))
        begin
            key_reg   <= nb_key;
            value_reg <= nb_value;
        end
    end

    assign cell_key   = key_reg;
    assign cell_value = value_reg;

    // Leaf of the reduction tree: zero unless this cell holds the key
    assign leaf = match_reg ? {1'b1, MY_IDX, value_reg} : '0;

endmodule

// ===== hdl/lkv_or_tree.sv =====
module lkv_or_tree
    import lkv_pkg::*;
#(
    parameter int N = 1024,
    parameter int W = 43
)(
    input  logic         clk,
    input  logic [W-1:0] leaves [N],
    output logic [W-1:0] root
);

    localparam int LEVELS = lkv_tree_levels(N);
    localparam int P      = TREE_RADIX ** LEVELS;
    localparam int TOTAL  = lkv_level_base(LEVELS + 1, LEVELS);

    logic [W-1:0] leaf_pad  [P];
    logic [W-1:0] node_reg  [TOTAL];

    // Pad the leaf row to a full tree
    for (genvar i = 0; i < P; i++) begin : g_pad
        if (i < N) begin : g_live
            assign leaf_pad[i] = leaves[i];
        end
        else begin : g_zero
            assign leaf_pad[i] = '0;
        end
    end

    // One registered level per radix step; at most one leaf is nonzero
    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int NODES = TREE_RADIX ** (LEVELS - l);
        localparam int BASE  = lkv_level_base(l, LEVELS);
        localparam int PREV  = (l > 1) ? lkv_level_base(l - 1, LEVELS) : 0;
        for (genvar n = 0; n < NODES; n++) begin : g_node
            logic [W-1:0] acc;
            if (l == 1) begin : g_first
                // Level next to the leaves
                always_comb
                begin
                    acc = '0;
                    for (int r = 0; r < TREE_RADIX; r++)
                    begin
                        acc = acc | leaf_pad[n * TREE_RADIX + r];
                    end
                end
            end
            else begin : g_upper
                // Level fed by the registered level below
                always_comb
                begin
                    acc = '0;
                    for (int r = 0; r < TREE_RADIX; r++)
                    begin
                        acc = acc | node_reg[PREV + n * TREE_RADIX + r];
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                node_reg[BASE + n] <= acc;
            end
        end
    end

    assign root = node_reg[TOTAL - 1];

endmodule

// ===== hdl/linear_key_value_table.sv =====
// Channel  Handshake            Payload
// -------  -------------------  --------------------------------------
// in       in_valid / in_ready  req_type, key, new_value
// out      out_valid/out_ready  value, found, status, entry_total
//
// One item at a time, in order: accept, key compare in every cell, LEVELS
// registered steps of the radix-16 match tree, then the update of the cell row.
// Reset empties the table at once by clearing the fill count; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile,
// and only the update step stalls while that register is still full.
module linear_key_value_table
    import lkv_pkg::*;
#(
    parameter int CAPACITY = LKV_CAPACITY
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  new_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  value,
    output logic                found,
    output logic [STATUS_W-1:0] status,
    output logic [TOTAL_W-1:0]  entry_total
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEAF_W = 1 + IDX_W + VALUE_W;
    localparam int LEVELS = lkv_tree_levels(CAPACITY);
    localparam int TW     = $clog2(LEVELS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_TREE,
        ST_UPDATE
    } state_t;

    state_t              state_reg;
    logic [TW-1:0]       tree_cnt_reg;
    logic [REQ_W-1:0]    req_type_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  new_value_reg;
    logic [CNT_W-1:0]    entry_count_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                found_reg;
    lkv_status_t         status_reg;
    logic [TOTAL_W-1:0]  entry_total_reg;

    logic [CNT_W-1:0]    count_next;
    logic [VALUE_W-1:0]  value_next;
    lkv_status_t         status_next;
    logic [VALUE_W-1:0]  wr_value;
    logic                has_room;
    logic                hit;
    logic [IDX_W-1:0]    hit_slot;
    logic [VALUE_W-1:0]  hit_value;
    logic                fire;
    lkv_cell_ctrl_t      upd_ctrl;
    lkv_cell_ctrl_t      cell_ctrl;

    logic [KEY_W-1:0]    cell_key   [CAPACITY];
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    logic [LEAF_W-1:0]   leaf       [CAPACITY];
    logic [LEAF_W-1:0]   root;

    // Row of cells, each handing its entry down to the one below on delete
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0]   nb_key;
        logic [VALUE_W-1:0] nb_value;
        if (i == CAPACITY - 1) begin : g_last
            assign nb_key   = cell_key[i];
            assign nb_value = cell_value[i];
        end
        else begin : g_mid
            assign nb_key   = cell_key[i + 1];
            assign nb_value = cell_value[i + 1];
        end
        lkv_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .count      (entry_count_reg),
            .slot       (hit_slot),
            .req_key    (key_reg),
            .wr_value   (wr_value),
            .nb_key     (nb_key),
            .nb_value   (nb_value),
            .cell_key   (cell_key[i]),
            .cell_value (cell_value[i]),
            .leaf       (leaf[i])
        );
    end

    // Collect hit flag, slot and value of the single matching cell
    lkv_or_tree #(
        .N (CAPACITY),
        .W (LEAF_W)
    ) u_tree (
        .clk    (clk),
        .leaves (leaf),
        .root   (root)
    );

    assign hit       = root[LEAF_W-1];
    assign hit_slot  = root[IDX_W+VALUE_W-1:VALUE_W];
    assign hit_value = root[VALUE_W-1:0];
    assign wr_value  = (req_type_reg == REQ_ASSIGN) ? new_value_reg : '0;
    assign has_room  = entry_count_reg < CNT_W'(CAPACITY);
    assign fire      = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);

    // Result and row update for the request in hand
    always_comb
    begin
        count_next  = entry_count_reg;
        value_next  = '0;
        status_next = STATUS_OK;
        upd_ctrl    = '0;
        case (req_type_reg)
            REQ_TOUCH, REQ_ASSIGN:
            begin
                if (hit)
                begin
                    upd_ctrl.write_hit = (req_type_reg == REQ_ASSIGN);
                    value_next         = (req_type_reg == REQ_ASSIGN) ? new_value_reg
                                                                      : hit_value;
                end
                else if (has_room)
                begin
                    upd_ctrl.insert = 1'b1;
                    value_next      = wr_value;
                    count_next      = entry_count_reg + 1'b1;
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            REQ_DELETE:
            begin
                if (hit)
                begin
                    upd_ctrl.shift = 1'b1;
                    count_next     = entry_count_reg - 1'b1;
                end
                else
                begin
                    status_next = STATUS_MISSING;
                end
            end
            REQ_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                value_next = hit_value;
            end
        endcase

        cell_ctrl           = '0;
        cell_ctrl.compare   = (state_reg == ST_MATCH);
        cell_ctrl.write_hit = fire && upd_ctrl.write_hit;
        cell_ctrl.insert    = fire && upd_ctrl.insert;
        cell_ctrl.shift     = fire && upd_ctrl.shift;
    end

    // Sequencer, request hold, fill count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tree_cnt_reg    <= '0;
            req_type_reg    <= '0;
            key_reg         <= '0;
            new_value_reg   <= '0;
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            value_reg       <= '0;
            found_reg       <= 1'b0;
            status_reg      <= STATUS_OK;
            entry_total_reg <= '0;
        end
        else
        begin
            // Result taken and no new one arriving in the same cycle
            if (out_valid_reg && out_ready && !fire)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_type_reg  <= req_type;
                        key_reg       <= key;
                        new_value_reg <= new_value;
                        state_reg     <= ST_MATCH;
                    end
                end
                ST_MATCH:
                begin
                    tree_cnt_reg <= TW'(LEVELS - 1);
                    state_reg    <= ST_TREE;
                end
                ST_TREE:
                begin
                    if (tree_cnt_reg == '0)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        tree_cnt_reg <= tree_cnt_reg - 1'b1;
                    end
                end
                ST_UPDATE:
                begin
                    if (fire)
                    begin
                        entry_count_reg <= count_next;
                        out_valid_reg   <= 1'b1;
                        value_reg       <= value_next;
                        found_reg       <= hit;
                        status_reg      <= status_next;
                        entry_total_reg <= TOTAL_W'(count_next);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign entry_total = entry_total_reg;

    // Fill count never passes the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // Only one item in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in flight");

    // A refused insert never reports a hit or a value
    a_full_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_FULL)) |-> (!found && (value == '0)))
        else $error("full status with hit or value");

    // A failed delete leaves the count alone
    a_missing_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (status_next == STATUS_MISSING)) |=> $stable(entry_count_reg))
        else $error("missing-key delete changed the count");

    // Update step always produces a result
    a_update_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("update without result");

endmodule

// ===== tb/tb_linear_key_value_table.sv =====
`timescale 1ns / 1ps

module tb_linear_key_value_table;
    import lkv_pkg::*;

    localparam int TABLE_CAPACITY = LKV_CAPACITY;
    localparam int RANDOM_ITEMS   = 625;
    localparam int TAIL_ITEMS     = 60;
    localparam int POOL_SIZE      = 32;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PLAN_ROWS      = 23;

    // Unused request codes; the block treats them as a lookup
    localparam logic [REQ_W-1:0] REQ_SPARE0 = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE1 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE2 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               found;
        lkv_status_t        status;
        logic [TOTAL_W-1:0] total;
    } table_result_t;

    // One request item, with an optional hand-written result
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] nv;
        logic               typed;
        table_result_t      result;
    } request_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  new_value;
    logic                out_valid;
    logic                out_ready;
    logic [VALUE_W-1:0]  value;
    logic                found;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  entry_total;

    // Hand-written result travels with the item on offer
    logic                offer_typed;
    table_result_t       offer_result;

    // Shadow copy of the table
    logic [KEY_W-1:0]    shadow_keys [TABLE_CAPACITY];
    logic [VALUE_W-1:0]  shadow_vals [TABLE_CAPACITY];
    int                  shadow_count;

    table_result_t       owed_results [$];
    int                  error_count;
    int                  quiet_cycles;
    bit                  gaps_on;
    bit                  stalls_on;
    bit                  long_hold;

    // Directed items: extremes, every kind, missing delete, shift on delete, clear
    request_t plan [PLAN_ROWS] = '{
        '{REQ_LOOKUP, 32'h0000_0000, 32'hdead_beef, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd0}},
        '{REQ_DELETE, 32'h8000_0000, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_MISSING, 11'd0}},
        '{REQ_ASSIGN, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
            '{32'h7fff_ffff, 1'b0, STATUS_OK, 11'd1}},
        '{REQ_TOUCH,  32'h7fff_ffff, 32'hffff_ffff, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd2}},
        '{REQ_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b1,
            '{32'h7fff_ffff, 1'b1, STATUS_OK, 11'd2}},
        '{REQ_ASSIGN, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
            '{32'h8000_0000, 1'b1, STATUS_OK, 11'd2}},
        '{REQ_TOUCH,  32'h7fff_ffff, 32'h1234_5678, 1'b1,
            '{32'h8000_0000, 1'b1, STATUS_OK, 11'd2}},
        '{REQ_ASSIGN, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{REQ_ASSIGN, 32'hffff_ffff, 32'hffff_ffff, 1'b0, '0},
        '{REQ_ASSIGN, 32'h0000_0001, 32'h5555_5555, 1'b0, '0},
        '{REQ_TOUCH,  32'haaaa_aaaa, 32'h5555_5555, 1'b0, '0},
        '{REQ_SPARE0, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{REQ_SPARE1, 32'haaaa_aaaa, 32'hffff_ffff, 1'b0, '0},
        '{REQ_SPARE2, 32'h0000_0002, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd6}},
        '{REQ_DELETE, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b1, STATUS_OK, 11'd5}},
        '{REQ_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 1'b0, '0},
        '{REQ_DELETE, 32'h7fff_ffff, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_MISSING, 11'd5}},
        '{REQ_DELETE, 32'haaaa_aaaa, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b1, STATUS_OK, 11'd4}},
        '{REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, '0},
        '{REQ_CLEAR,  32'h0000_0001, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b1, STATUS_OK, 11'd0}},
        '{REQ_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd0}},
        '{REQ_CLEAR,  32'h0000_0005, 32'h0000_0000, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd0}},
        '{REQ_TOUCH,  32'h1234_5678, 32'hffff_ffff, 1'b1,
            '{32'h0000_0000, 1'b0, STATUS_OK, 11'd1}}
    };

    linear_key_value_table #(
        .CAPACITY(TABLE_CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .req_type(req_type),
        .key(key),
        .new_value(new_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value(value),
        .found(found),
        .status(status),
        .entry_total(entry_total)
    );

    always #5 clk = ~clk;

    // Applies one request to the shadow table and returns its result
    function automatic table_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                    input logic [KEY_W-1:0] k,
                                                    input logic [VALUE_W-1:0] nv);
        table_result_t r;
        int            slot;
        bit            hit;
        slot = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--)
        begin
            if (shadow_keys[i] == k)
                slot = i;
        end
        hit      = (slot < shadow_count);
        r        = '0;
        r.found  = hit;
        r.status = STATUS_OK;
        case (kind)
            REQ_TOUCH, REQ_ASSIGN:
            begin
                if (hit)
                begin
                    if (kind == REQ_ASSIGN)
                        shadow_vals[slot] = nv;
                    r.value = shadow_vals[slot];
                end
                else if (shadow_count < TABLE_CAPACITY)
                begin
                    shadow_keys[shadow_count] = k;
                    shadow_vals[shadow_count] = (kind == REQ_ASSIGN) ? nv : '0;
                    r.value = shadow_vals[shadow_count];
                    shadow_count++;
                end
                else
                    r.status = STATUS_FULL;
            end
            REQ_DELETE:
            begin
                if (hit)
                begin
                    // close the gap left by the removed entry
                    for (int j = slot; j < shadow_count - 1; j++)
                    begin
                        shadow_keys[j] = shadow_keys[j + 1];
                        shadow_vals[j] = shadow_vals[j + 1];
                    end
                    shadow_count--;
                end
                else
                    r.status = STATUS_MISSING;
            end
            REQ_CLEAR:
                shadow_count = 0;
            default:
            begin
                if (hit)
                    r.value = shadow_vals[slot];
            end
        endcase
        r.total = shadow_count[TOTAL_W-1:0];
        return r;
    endfunction

    // Offer one item, optionally after a gap, and wait until it is taken
    task automatic send_item(input request_t s);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= s.req;
        key          <= s.key;
        new_value    <= s.nv;
        offer_typed  <= s.typed;
        offer_result <= s.result;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin : scoreboard
        table_result_t want;
        table_result_t got;
        table_result_t predicted;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = apply_request(req_type, key, new_value);
                owed_results.push_back(offer_typed ? offer_result : predicted);
            end
            if (out_valid && out_ready)
            begin
                got.value  = value;
                got.found  = found;
                got.status = lkv_status_t'(status);
                got.total  = entry_total;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: unexpected result, got value %h found %b status %0d total %0d",
                             $time, got.value, got.found, got.status, got.total);
                    error_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value mismatch, expected %h, got %h",
                                 $time, want.value, got.value);
                        error_count++;
                    end
                    if (got.found !== want.found)
                    begin
                        $display("%0t: found mismatch, expected %b, got %b",
                                 $time, want.found, got.found);
                        error_count++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.total !== want.total)
                    begin
                        $display("%0t: entry_total mismatch, expected %0d, got %0d",
                                 $time, want.total, got.total);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random ready bursts, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        request_t         s;
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        int               pick;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_LOOKUP;
        key          = '0;
        new_value    = '0;
        offer_typed  = 1'b0;
        offer_result = '0;
        gaps_on      = 1'b1;
        stalls_on    = 1'b1;
        long_hold    = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items
        for (int i = 0; i < PLAN_ROWS; i++)
            send_item(plan[i]);

        // random items over a small key pool so that hits are common;
        // the tail runs with no idling on either side
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gaps_on   = (i < RANDOM_ITEMS - TAIL_ITEMS) && (((i / 80) % 3) != 2);
            stalls_on = (i < RANDOM_ITEMS - TAIL_ITEMS) && (((i / 60) % 4) != 3);
            if (i == 300)
                long_hold = 1'b1;
            s      = '0;
            pick   = $urandom_range(0, 99);
            if (pick < 30)
                s.req = REQ_LOOKUP;
            else if (pick < 45)
                s.req = REQ_TOUCH;
            else if (pick < 70)
                s.req = REQ_ASSIGN;
            else if (pick < 92)
                s.req = REQ_DELETE;
            else if (pick < 95)
                s.req = REQ_CLEAR;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       s.req = REQ_SPARE0;
                    1:       s.req = REQ_SPARE1;
                    default: s.req = REQ_SPARE2;
                endcase
            end
            if ($urandom_range(0, 99) < 85)
                s.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                s.key = $urandom;
            s.nv = $urandom;
            send_item(s);
        end

        // closing clear
        s     = '0;
        s.req = REQ_CLEAR;
        s.key = key_pool[0];
        send_item(s);
        in_valid <= 1'b0;

        // drain
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== linear_key_value_table.f =====
hdl/lkv_pkg.sv
hdl/lkv_cell.sv
hdl/lkv_or_tree.sv
hdl/linear_key_value_table.sv
tb/tb_linear_key_value_table.sv
